// File: rtl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and tables for the text glyph renderer
// Request and row payloads, queue job format, config register codes,
// character map ROM and the packed 6x7 font ROM.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int unsigned FontWordsDef  = 64;
  localparam int unsigned MapEntries    = 128;
  localparam int unsigned RomWords      = 64;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0]  NoGlyph     = 8'hFF;
  localparam logic [7:0]  NewlineChar = 8'h0A;
  localparam logic [9:0]  LeftMargin  = 10'd30;
  localparam logic [9:0]  LineStep    = 10'd10;
  localparam logic [9:0]  ColStep     = 10'd6;
  localparam logic [9:0]  RowMax      = 10'd1023;
  localparam logic [10:0] ResetWidth  = 11'd320;
  localparam logic [23:0] ResetBase   = 24'd0;
  localparam logic [9:0]  ResetCol    = 10'd30;
  localparam logic [9:0]  ResetRow    = 10'd25;
  localparam logic [15:0] PixOn       = 16'hFFFF;
  localparam logic [15:0] PixOff      = 16'h0001;
  localparam logic [2:0]  LastRowIdx  = 3'd6;

  localparam logic [0:0] OpCursor = 1'b0;

  typedef enum logic [0:0] {
    CfgScreenWidth = 1'b0,
    CfgFrameBase   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] character;
    logic [9:0] x_position;
    logic [9:0] y_position;
  } req_t;

  typedef struct packed {
    logic [23:0] pixel_offset;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic [15:0] pixel_e;
    logic [15:0] pixel_f;
    logic        last_row;
  } row_t;

  // one queued glyph: offset of its top row, font word group, column slot
  typedef struct packed {
    logic [23:0] offset;
    logic [3:0]  group;
    logic [2:0]  col;
  } job_t;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [23:0] frame_base;
  } cfg_t;

  localparam logic [7:0] CharMap [MapEntries] = '{
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'h29,8'hFF,8'hFF,8'hFF,8'h2B,8'hFF,8'hFF,
    8'h25,8'h26,8'hFF,8'h2A,8'hFF,8'h27,8'h2C,8'hFF,
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
    8'h08,8'h09,8'h24,8'hFF,8'hFF,8'hFF,8'hFF,8'h28,
    8'hFF,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,
    8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,
    8'h21,8'h22,8'h23,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'h0A,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,8'h10,
    8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,
    8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h20,
    8'h21,8'h22,8'h23,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
  };

  localparam logic [31:0] FontRom [RomWords] = '{
    32'h70871C30, 32'h8988A250, 32'h88808290, 32'h88831C90,
    32'h888402F8, 32'h88882210, 32'h71CF9C10, 32'hF9CF9C70,
    32'h8228A288, 32'hF200A288, 32'h0BC11C78, 32'h0A222208,
    32'h8A222288, 32'h71C21C70, 32'h23C738F8, 32'h5228A480,
    32'h8A282280, 32'h8BC822F0, 32'hFA282280, 32'h8A28A480,
    32'h8BC738F8, 32'hF9C89C08, 32'h82288808, 32'h82088808,
    32'hF2EF8808, 32'h82288888, 32'h82288888, 32'h81C89C70,
    32'h8A08A270, 32'h920DA288, 32'hA20AB288, 32'hC20AAA88,
    32'hA208A688, 32'h9208A288, 32'h8BE8A270, 32'hF1CF1CF8,
    32'h8A28A220, 32'h8A28A020, 32'hF22F1C20, 32'h82AA0220,
    32'h82492220, 32'h81A89C20, 32'h8A28A288, 32'h8A28A288,
    32'h8A289488, 32'h8A2A8850, 32'h894A9420, 32'h894AA220,
    32'h70852220, 32'hF8011000, 32'h08020800, 32'h10840400,
    32'h20040470, 32'h40840400, 32'h80020800, 32'hF8011000,
    32'h70800000, 32'h88822200, 32'h08820400, 32'h108F8800,
    32'h20821000, 32'h00022200, 32'h20800020, 32'h00000000
  };

endpackage

// File: rtl/text_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_glyph_renderer: 6x7 bitmap font character generator
// Turns text characters into framebuffer glyph rows with a running cursor.
// ----------------------------------------------------------------------------
// Each request carries one character. Its low 7 bits pick a glyph from a
// 128-entry map; a drawn glyph comes out as seven rows, each with the
// framebuffer pixel offset of its first pixel and six 16-bit pixels
// (0xFFFF for a set font bit, 0x0001 otherwise), last_row marking the
// seventh. Operation 0 prints at the running cursor: newline (byte 0x0A)
// moves to column 30 of the next text line (10 pixels down), any other
// byte advances the column by 6 and wraps past screen_width-30. Unmapped
// characters move the cursor but draw nothing. Operation 1 draws at the
// given x/y and leaves the cursor alone. Cursor rows saturate at 1023 and
// offsets wrap modulo 2^24.
//
// Rate: one output row per cycle while out_stall_i is low; a drawn glyph
// holds the row sequencer for its seven rows. Requests that draw nothing
// (newline, unmapped) never reach the queue. A glyph passes the front
// stages and the queue before the sequencer loads it. The front runs ahead
// of the sequencer by up to the queue depth plus its two pipeline stages.
//
// Config writes: index 0 = screen_width, 1 = frame_base; cfg_ready_o is
// always high. Write only while the block is idle.
module text_glyph_renderer import tgr_pkg::*; #(
  parameter int unsigned FontWords  = FontWordsDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // character requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  // glyph rows
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output row_t        out_data_o
);

  cfg_t cfg_q, cfg_d;
  logic job_push, job_full, job_valid, job_pop;
  job_t push_job, pop_job;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgScreenWidth: cfg_d.screen_width = cfg_data_i[10:0];
        CfgFrameBase:   cfg_d.frame_base   = cfg_data_i;
        default:        cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width <= ResetWidth;
      cfg_q.frame_base   <= ResetBase;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: map, cursor, top-row offset
  tgr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (job_push),
    .push_full_i  (job_full),
    .push_data_o  (push_job)
  );

  // decoupling queue
  tgr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_push),
    .full_o       (job_full),
    .push_data_i  (push_job),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_data_o   (pop_job)
  );

  // back: row sequencer and output register
  tgr_back #(
    .FontWords (FontWords)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .screen_width_i (cfg_q.screen_width),
    .job_valid_i    (job_valid),
    .job_pop_o      (job_pop),
    .job_i          (pop_job),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

// File: rtl/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front: request intake and classification
// Maps the character, runs the text cursor, and builds a job with the
// glyph's top-row framebuffer offset for the queue. Two register stages.
// ----------------------------------------------------------------------------
module tgr_front import tgr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  req_t  in_data_i,
  output logic  push_valid_o,
  input  logic  push_full_i,
  output job_t  push_data_o
);

  logic [9:0]  cursor_col_q, cursor_col_d;
  logic [9:0]  cursor_row_q, cursor_row_d;

  logic        s1_valid_q, s1_valid_d;
  logic [9:0]  s1_x_q, s1_y_q;
  logic [5:0]  s1_glyph_q;

  logic        s2_valid_q, s2_valid_d;
  logic [20:0] s2_prod_q;
  logic [9:0]  s2_x_q;
  logic [3:0]  s2_group_q;
  logic [2:0]  s2_col_q;

  logic        s1_free, s2_free, accept, mapped;
  logic [7:0]  glyph;
  logic [10:0] next_col;
  logic signed [12:0] wrap_limit;
  logic        wrap;
  logic [10:0] row_sum;
  logic [9:0]  next_row;
  logic [9:0]  draw_x, draw_y;
  logic [9:0]  grp_mul;
  logic [3:0]  group;
  logic [5:0]  col_diff;

  assign s2_free    = !s2_valid_q || !push_full_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  assign glyph  = CharMap[in_data_i.character[6:0]];
  assign mapped = (glyph != NoGlyph);

  // cursor arithmetic; wrap limit is signed so narrow screens always wrap
  assign next_col   = {1'b0, cursor_col_q} + {1'b0, ColStep};
  assign wrap_limit = $signed({2'b00, cfg_i.screen_width}) - $signed({3'b000, LeftMargin});
  assign wrap       = ($signed({2'b00, next_col}) > wrap_limit) ||
                      (next_col > {1'b0, RowMax});
  assign row_sum    = {1'b0, cursor_row_q} + {1'b0, LineStep};
  assign next_row   = (row_sum > {1'b0, RowMax}) ? RowMax : row_sum[9:0];

  always_comb begin
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    if (accept && (in_data_i.operation == OpCursor)) begin
      if ((in_data_i.character == NewlineChar) || wrap) begin
        cursor_col_d = LeftMargin;
        cursor_row_d = next_row;
      end else begin
        cursor_col_d = next_col[9:0];
      end
    end
  end

  assign draw_x = (in_data_i.operation == OpCursor) ? cursor_col_q : in_data_i.x_position;
  assign draw_y = (in_data_i.operation == OpCursor) ? cursor_row_q : in_data_i.y_position;

  // newline maps to no glyph, so only drawn glyphs enter the pipe
  assign s1_valid_d = s1_free ? (accept && mapped) : s1_valid_q;

  // glyph / 5 by reciprocal (exact for 6-bit glyph numbers), remainder by subtract
  assign grp_mul  = 10'(s1_glyph_q) * 10'd13;
  assign group    = grp_mul[9:6];
  assign col_diff = s1_glyph_q - 6'({group, 2'b00} + {2'b00, group});

  assign s2_valid_d = s2_free ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= ResetCol;
      cursor_row_q <= ResetRow;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
    end else begin
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      s1_valid_q   <= s1_valid_d;
      s2_valid_q   <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= draw_x;
      s1_y_q     <= draw_y;
      s1_glyph_q <= glyph[5:0];
    end
    if (s2_free) begin
      s2_prod_q  <= 21'(cfg_i.screen_width) * 21'(s1_y_q);
      s2_x_q     <= s1_x_q;
      s2_group_q <= group;
      s2_col_q   <= col_diff[2:0];
    end
  end

  assign push_valid_o       = s2_valid_q;
  assign push_data_o.offset = cfg_i.frame_base + 24'(s2_prod_q) + 24'(s2_x_q);
  assign push_data_o.group  = s2_group_q;
  assign push_data_o.col    = s2_col_q;

endmodule

// File: rtl/tgr_queue.sv
// ----------------------------------------------------------------------------
// tgr_queue: short job queue between front and back
// Register-based FIFO; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module tgr_queue import tgr_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic full_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign do_push     = push_valid_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back: glyph row sequencer
// Walks the seven font words of a queued glyph, one row per unstalled cycle,
// into the output register; the offset steps by one screen line per row.
// ----------------------------------------------------------------------------
module tgr_back import tgr_pkg::*; #(
  parameter int unsigned FontWords = FontWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [10:0] screen_width_i,
  input  logic        job_valid_i,
  output logic        job_pop_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output row_t        out_data_o
);

  logic        busy_q, busy_d;
  logic [2:0]  row_q, row_d;
  logic [6:0]  word_q, word_d;
  logic [23:0] off_q, off_d;
  logic [2:0]  col_q;
  logic        out_valid_q, out_valid_d;
  row_t        out_q;

  logic        out_free, emit, done, load;
  logic [31:0] bits;
  logic [5:0]  sel;
  row_t        row_val;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_free;
  assign done      = emit && (row_q == LastRowIdx);
  assign load      = job_valid_i && (!busy_q || done);
  assign job_pop_o = load;

  // words past the font end read as blank
  assign bits = (word_q < 7'(FontWords)) ? FontRom[word_q[5:0]] : 32'd0;

  always_comb begin
    case (col_q)
      3'd0:    sel = bits[31:26];
      3'd1:    sel = bits[25:20];
      3'd2:    sel = bits[19:14];
      3'd3:    sel = bits[13:8];
      3'd4:    sel = bits[7:2];
      default: sel = 6'd0;
    endcase
  end

  assign row_val.pixel_offset = off_q;
  assign row_val.pixel_a      = sel[5] ? PixOn : PixOff;
  assign row_val.pixel_b      = sel[4] ? PixOn : PixOff;
  assign row_val.pixel_c      = sel[3] ? PixOn : PixOff;
  assign row_val.pixel_d      = sel[2] ? PixOn : PixOff;
  assign row_val.pixel_e      = sel[1] ? PixOn : PixOff;
  assign row_val.pixel_f      = sel[0] ? PixOn : PixOff;
  assign row_val.last_row     = (row_q == LastRowIdx);

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    word_d = word_q;
    off_d  = off_q;
    if (emit) begin
      row_d  = row_q + 1'b1;
      word_d = word_q + 1'b1;
      off_d  = off_q + 24'(screen_width_i);
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      row_d  = '0;
      word_d = {job_i.group, 3'b000} - {3'b000, job_i.group};
      off_d  = job_i.offset;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    off_q  <= off_d;
    if (load) begin
      col_q <= job_i.col;
    end
    if (emit) begin
      out_q <= row_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
